FILE: sv/rrts_pkg.sv
// shared constants, codes and controller/datapath interface types
// for the round-robin task scheduler; no dependencies
package rrts_pkg;

    localparam int TABLE_DEPTH = 16;
    localparam int IDX_W       = $clog2(TABLE_DEPTH);
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
    localparam int PID_W       = 16;
    localparam int SLICE_W     = 8;
    localparam int TICKS_W     = 32;

    localparam logic [1:0] CMD_TICK   = 2'd0;
    localparam logic [1:0] CMD_YIELD  = 2'd1;
    localparam logic [1:0] CMD_CREATE = 2'd2;
    localparam logic [1:0] CMD_KILL   = 2'd3;

    localparam logic [1:0] TS_READY   = 2'd0;
    localparam logic [1:0] TS_RUNNING = 2'd1;
    localparam logic [1:0] TS_BLOCKED = 2'd2;
    localparam logic [1:0] TS_DEAD    = 2'd3;

    localparam logic [1:0] STAT_OK        = 2'd0;
    localparam logic [1:0] STAT_FULL      = 2'd1;
    localparam logic [1:0] STAT_NOT_FOUND = 2'd2;
    localparam logic [1:0] STAT_PROTECTED = 2'd3;

    localparam logic CFG_IDLE_SLICE = 1'b0;
    localparam logic CFG_TASK_SLICE = 1'b1;

    localparam logic [PID_W-1:0]   IDLE_PID       = 16'd1;
    localparam logic [PID_W-1:0]   FIRST_PID      = 16'd2;
    localparam logic [SLICE_W-1:0] IDLE_SLICE_RST = 8'd10;
    localparam logic [SLICE_W-1:0] TASK_SLICE_RST = 8'd20;

    typedef struct packed {
        logic accept;
        logic scan_zero;
        logic tick;
        logic create;
        logic kill_step;
        logic rs_start;
        logic rs_step;
        logic rs_fin;
    } t_dp_cmd;

    typedef struct packed {
        logic expired;
        logic kill_done;
        logic rs_hit;
        logic rs_wrap;
    } t_dp_stat;

endpackage

FILE: sv/rrts_ctrl.sv
// command sequencer of the round-robin task scheduler
// depends on rrts_pkg for the command codes and datapath interface types
module rrts_ctrl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [1:0]         i_cmd,
    input  rrts_pkg::t_dp_stat i_stat,
    output rrts_pkg::t_dp_cmd  o_cmd,
    output logic               o_busy,
    output logic               o_valid
);

    typedef enum logic [7:0] {
        S_IDLE     = 8'b0000_0001,
        S_TICK     = 8'b0000_0010,
        S_CREATE   = 8'b0000_0100,
        S_KILL     = 8'b0000_1000,
        S_RS_START = 8'b0001_0000,
        S_RS_SCAN  = 8'b0010_0000,
        S_RS_FIN   = 8'b0100_0000,
        S_DONE     = 8'b1000_0000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    o_cmd.accept    = 1'b1;
                    o_cmd.scan_zero = (i_cmd == rrts_pkg::CMD_KILL);
                    unique case (i_cmd)
                        rrts_pkg::CMD_TICK:   n_state = S_TICK;
                        rrts_pkg::CMD_YIELD:  n_state = S_RS_START;
                        rrts_pkg::CMD_CREATE: n_state = S_CREATE;
                        rrts_pkg::CMD_KILL:   n_state = S_KILL;
                        default:              n_state = S_IDLE;
                    endcase
                end
            end
            S_TICK: begin
                o_cmd.tick = 1'b1;
                n_state    = i_stat.expired ? S_RS_START : S_DONE;
            end
            S_CREATE: begin
                o_cmd.create = 1'b1;
                n_state      = S_DONE;
            end
            S_KILL: begin
                o_cmd.kill_step = 1'b1;
                if (i_stat.kill_done) begin
                    n_state = S_DONE;
                end
            end
            S_RS_START: begin
                o_cmd.rs_start = 1'b1;
                n_state        = i_stat.rs_wrap ? S_RS_FIN : S_RS_SCAN;
            end
            S_RS_SCAN: begin
                o_cmd.rs_step = 1'b1;
                if (i_stat.rs_hit || i_stat.rs_wrap) begin
                    n_state = S_RS_FIN;
                end
            end
            S_RS_FIN: begin
                o_cmd.rs_fin = 1'b1;
                n_state      = S_DONE;
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_busy  = (r_state != S_IDLE);
    assign o_valid = (r_state == S_DONE);

endmodule

FILE: sv/rrts_dpath.sv
// task table, slice counters, scan pointer and result registers
// depends on rrts_pkg; driven by rrts_ctrl through t_dp_cmd / t_dp_stat
module rrts_dpath (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  rrts_pkg::t_dp_cmd            i_cmd,
    output rrts_pkg::t_dp_stat           o_stat,
    input  logic [rrts_pkg::PID_W-1:0]   i_target_pid,
    input  logic                         i_cfg_we,
    input  logic                         i_cfg_index,
    input  logic [rrts_pkg::SLICE_W-1:0] i_cfg_data,
    output logic [1:0]                   o_status,
    output logic [rrts_pkg::PID_W-1:0]   o_new_pid,
    output logic [rrts_pkg::PID_W-1:0]   o_current_pid,
    output logic                         o_rescheduled
);

    logic [1:0]                   r_status [rrts_pkg::TABLE_DEPTH];
    logic [rrts_pkg::PID_W-1:0]   r_ident  [rrts_pkg::TABLE_DEPTH];
    logic [rrts_pkg::SLICE_W-1:0] r_slice  [rrts_pkg::TABLE_DEPTH];
    logic [rrts_pkg::TICKS_W-1:0] r_ticks  [rrts_pkg::TABLE_DEPTH];

    logic [rrts_pkg::CNT_W-1:0]   r_live;
    logic [rrts_pkg::IDX_W-1:0]   r_cur;
    logic [rrts_pkg::PID_W-1:0]   r_cur_pid;
    logic [rrts_pkg::PID_W-1:0]   r_pid_ctr;
    logic [rrts_pkg::IDX_W-1:0]   r_scan;
    logic [rrts_pkg::IDX_W-1:0]   r_pick;
    logic [rrts_pkg::PID_W-1:0]   r_pick_pid;
    logic [rrts_pkg::PID_W-1:0]   r_target;
    logic [rrts_pkg::SLICE_W-1:0] r_idle_slice;
    logic [rrts_pkg::SLICE_W-1:0] r_task_slice;
    logic [1:0]                   r_res_status;
    logic [rrts_pkg::PID_W-1:0]   r_res_new_pid;
    logic                         r_res_resched;

    logic [rrts_pkg::CNT_W-1:0]   scan_inc;
    logic [rrts_pkg::IDX_W-1:0]   scan_next;
    logic [1:0]                   scan_st;
    logic [rrts_pkg::PID_W-1:0]   scan_id;
    logic                         kill_idle;
    logic                         kill_hit;
    logic                         kill_last;
    logic [rrts_pkg::SLICE_W-1:0] slice_inc;
    logic [rrts_pkg::SLICE_W-1:0] slice_lim;
    logic                         expired;
    logic                         table_full;
    logic                         do_create;
    logic [rrts_pkg::IDX_W-1:0]   slot;
    logic                         st_we;
    logic [rrts_pkg::IDX_W-1:0]   st_addr;
    logic [1:0]                   st_data;

    assign scan_inc  = rrts_pkg::CNT_W'(r_scan) + rrts_pkg::CNT_W'(1);
    assign scan_next = (scan_inc >= r_live) ? '0 : scan_inc[rrts_pkg::IDX_W-1:0];
    assign scan_st   = r_status[r_scan];
    assign scan_id   = r_ident[r_scan];

    assign kill_idle = (r_target == rrts_pkg::IDLE_PID);
    assign kill_hit  = (scan_id == r_target);
    assign kill_last = (scan_inc == r_live);

    assign slice_inc = r_slice[r_cur] + rrts_pkg::SLICE_W'(1);
    assign slice_lim = (r_cur == '0) ? r_idle_slice : r_task_slice;
    assign expired   = (slice_inc >= slice_lim);

    assign table_full = (r_live >= rrts_pkg::CNT_W'(rrts_pkg::TABLE_DEPTH));
    assign do_create  = i_cmd.create && !table_full;
    assign slot       = r_live[rrts_pkg::IDX_W-1:0];

    assign o_stat.expired   = expired;
    assign o_stat.kill_done = kill_idle || kill_hit || kill_last;
    assign o_stat.rs_hit    = (scan_st == rrts_pkg::TS_READY) ||
                              (scan_st == rrts_pkg::TS_RUNNING);
    assign o_stat.rs_wrap   = (scan_next == r_cur);

    always_comb begin
        st_we   = 1'b0;
        st_addr = r_scan;
        st_data = rrts_pkg::TS_READY;
        if (i_cmd.kill_step && !kill_idle && kill_hit) begin
            st_we   = 1'b1;
            st_data = rrts_pkg::TS_DEAD;
        end else if (do_create) begin
            st_we   = 1'b1;
            st_addr = slot;
        end else if (i_cmd.rs_start && scan_st == rrts_pkg::TS_RUNNING) begin
            st_we   = 1'b1;
        end else if (i_cmd.rs_fin) begin
            st_we   = 1'b1;
            st_addr = r_pick;
            st_data = rrts_pkg::TS_RUNNING;
        end
    end

    // only the idle entry has a defined reset value in status and pid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_status[0] <= rrts_pkg::TS_READY;
            r_ident[0]  <= rrts_pkg::IDLE_PID;
        end else begin
            if (st_we) begin
                r_status[st_addr] <= st_data;
            end
            if (do_create) begin
                r_ident[slot] <= r_pid_ctr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < rrts_pkg::TABLE_DEPTH; k++) begin
                r_slice[k] <= '0;
                r_ticks[k] <= '0;
            end
        end else if (i_cmd.tick) begin
            r_slice[r_cur] <= expired ? '0 : slice_inc;
            r_ticks[r_cur] <= r_ticks[r_cur] + rrts_pkg::TICKS_W'(1);
        end else if (do_create) begin
            r_slice[slot] <= '0;
            r_ticks[slot] <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_live        <= rrts_pkg::CNT_W'(1);
            r_cur         <= '0;
            r_cur_pid     <= rrts_pkg::IDLE_PID;
            r_pid_ctr     <= rrts_pkg::FIRST_PID;
            r_scan        <= '0;
            r_pick        <= '0;
            r_pick_pid    <= '0;
            r_target      <= '0;
            r_idle_slice  <= rrts_pkg::IDLE_SLICE_RST;
            r_task_slice  <= rrts_pkg::TASK_SLICE_RST;
            r_res_status  <= rrts_pkg::STAT_OK;
            r_res_new_pid <= '0;
            r_res_resched <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == rrts_pkg::CFG_IDLE_SLICE) begin
                    r_idle_slice <= i_cfg_data;
                end else begin
                    r_task_slice <= i_cfg_data;
                end
            end
            if (i_cmd.accept) begin
                r_target      <= i_target_pid;
                r_scan        <= i_cmd.scan_zero ? '0 : r_cur;
                r_res_status  <= rrts_pkg::STAT_OK;
                r_res_new_pid <= '0;
                r_res_resched <= 1'b0;
            end
            if (i_cmd.create) begin
                if (table_full) begin
                    r_res_status <= rrts_pkg::STAT_FULL;
                end else begin
                    r_res_new_pid <= r_pid_ctr;
                    r_pid_ctr     <= r_pid_ctr + rrts_pkg::PID_W'(1);
                    r_live        <= r_live + rrts_pkg::CNT_W'(1);
                end
            end
            if (i_cmd.kill_step) begin
                if (kill_idle) begin
                    r_res_status <= rrts_pkg::STAT_PROTECTED;
                end else if (!kill_hit) begin
                    if (kill_last) begin
                        r_res_status <= rrts_pkg::STAT_NOT_FOUND;
                    end else begin
                        r_scan <= scan_next;
                    end
                end
            end
            if (i_cmd.rs_start) begin
                r_res_resched <= 1'b1;
                r_pick        <= r_scan;
                r_pick_pid    <= r_cur_pid;
                r_scan        <= scan_next;
            end
            if (i_cmd.rs_step) begin
                if (o_stat.rs_hit) begin
                    r_pick     <= r_scan;
                    r_pick_pid <= scan_id;
                end else begin
                    r_scan <= scan_next;
                end
            end
            if (i_cmd.rs_fin) begin
                r_cur     <= r_pick;
                r_cur_pid <= r_pick_pid;
            end
        end
    end

    assign o_status      = r_res_status;
    assign o_new_pid     = r_res_new_pid;
    assign o_current_pid = r_cur_pid;
    assign o_rescheduled = r_res_resched;

endmodule

FILE: sv/round_robin_task_scheduler.sv
// top level of the round-robin task scheduler
// depends on rrts_pkg, rrts_ctrl and rrts_dpath
//
// Command channel: a command (i_cmd, i_target_pid) is taken at a rising edge
// with i_start high and o_busy low. o_busy stays high until the result has
// been shown. Each command gives exactly one result: o_valid is high for one
// cycle with o_status, o_new_pid, o_current_pid and o_rescheduled, and the
// transfer completes at the end of that cycle; the receiver cannot stall it.
// States from acceptance to o_valid (o_busy is low again in the cycle after):
//   tick without slice expiry: S_TICK, S_DONE; create: S_CREATE, S_DONE
//   kill: S_KILL once per entry scanned (1 to live task count), S_DONE
//   yield: S_RS_START, S_RS_SCAN once per entry scanned after the current one
//   (0 to live count - 1), S_RS_FIN, S_DONE; a tick with expiry adds S_TICK first
// The table is scanned one entry per cycle through a single scan pointer.
// Configuration channel: i_cfg_valid with i_cfg_index (0 idle slice,
// 1 task slice) and i_cfg_data; o_cfg_ready is always high, and writes are
// meant to land only while no command is in flight.
// Reset (i_rst_n low, synchronous) leaves the idle task, pid 1, alone in the
// table with slices 10 and 20 and the next pid at 2; no clearing pass.
module round_robin_task_scheduler (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_start,
    output logic                         o_busy,
    input  logic [1:0]                   i_cmd,
    input  logic [rrts_pkg::PID_W-1:0]   i_target_pid,
    output logic                         o_valid,
    output logic [1:0]                   o_status,
    output logic [rrts_pkg::PID_W-1:0]   o_new_pid,
    output logic [rrts_pkg::PID_W-1:0]   o_current_pid,
    output logic                         o_rescheduled,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic                         i_cfg_index,
    input  logic [rrts_pkg::SLICE_W-1:0] i_cfg_data
);

    rrts_pkg::t_dp_cmd  dp_cmd;
    rrts_pkg::t_dp_stat dp_stat;

    assign o_cfg_ready = 1'b1;

    rrts_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_start),
        .i_cmd   (i_cmd),
        .i_stat  (dp_stat),
        .o_cmd   (dp_cmd),
        .o_busy  (o_busy),
        .o_valid (o_valid)
    );

    rrts_dpath u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (dp_cmd),
        .o_stat        (dp_stat),
        .i_target_pid  (i_target_pid),
        .i_cfg_we      (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_status      (o_status),
        .o_new_pid     (o_new_pid),
        .o_current_pid (o_current_pid),
        .o_rescheduled (o_rescheduled)
    );

`ifndef SYNTHESIS
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_start && !o_busy) |=> (o_busy && !o_valid))
        else $error("accepted command did not raise busy");

    a_done_release: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |=> !o_busy)
        else $error("busy held after result transfer");

    a_resched_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_rescheduled) |-> (o_status == rrts_pkg::STAT_OK))
        else $error("reschedule reported with error status");

    a_pid_on_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_status != rrts_pkg::STAT_OK) |-> (o_new_pid == '0))
        else $error("new pid given on failed command");
`endif

endmodule

FILE: verif/tb_round_robin_task_scheduler.sv
// self-checking testbench for the round-robin task scheduler: directed and random commands,
// slice settings changed between phases, results checked against a built-in scheduler model
// depends on rrts_pkg and round_robin_task_scheduler
module tb_round_robin_task_scheduler;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SETTLE_CYCLES = 30;
    localparam int DRAIN_LIMIT   = 500;

    typedef struct packed {
        logic [1:0]                 status;
        logic [rrts_pkg::PID_W-1:0] new_pid;
        logic [rrts_pkg::PID_W-1:0] current_pid;
        logic                       rescheduled;
    } t_sched_result;

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         i_start;
    logic                         o_busy;
    logic [1:0]                   i_cmd;
    logic [rrts_pkg::PID_W-1:0]   i_target_pid;
    logic                         o_valid;
    logic [1:0]                   o_status;
    logic [rrts_pkg::PID_W-1:0]   o_new_pid;
    logic [rrts_pkg::PID_W-1:0]   o_current_pid;
    logic                         o_rescheduled;
    logic                         i_cfg_valid;
    logic                         o_cfg_ready;
    logic                         i_cfg_index;
    logic [rrts_pkg::SLICE_W-1:0] i_cfg_data;

    round_robin_task_scheduler dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (i_start),
        .o_busy        (o_busy),
        .i_cmd         (i_cmd),
        .i_target_pid  (i_target_pid),
        .o_valid       (o_valid),
        .o_status      (o_status),
        .o_new_pid     (o_new_pid),
        .o_current_pid (o_current_pid),
        .o_rescheduled (o_rescheduled),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    // scheduler model state
    logic [1:0]                   tbl_state [rrts_pkg::TABLE_DEPTH];
    logic [rrts_pkg::PID_W-1:0]   tbl_pid   [rrts_pkg::TABLE_DEPTH];
    logic [rrts_pkg::SLICE_W-1:0] tbl_used  [rrts_pkg::TABLE_DEPTH];
    logic [rrts_pkg::TICKS_W-1:0] tbl_ticks [rrts_pkg::TABLE_DEPTH];
    int                           live_tasks;
    int                           cur_slot;
    logic [rrts_pkg::PID_W-1:0]   pid_next;
    logic [rrts_pkg::SLICE_W-1:0] idle_slice_m;
    logic [rrts_pkg::SLICE_W-1:0] task_slice_m;

    t_sched_result pending_results[$];
    t_sched_result got_want;

    int  mismatches = 0;
    int  n_cmds = 0;
    int  n_resched = 0;
    int  n_created = 0;
    int  n_full = 0;
    int  n_kill_ok = 0;
    int  n_kill_missing = 0;
    int  n_kill_protected = 0;
    bit  gaps_on = 1'b1;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic void model_reset();
        for (int i = 0; i < rrts_pkg::TABLE_DEPTH; i++) begin
            tbl_state[i] = rrts_pkg::TS_READY;
            tbl_pid[i]   = '0;
            tbl_used[i]  = '0;
            tbl_ticks[i] = '0;
        end
        tbl_pid[0]   = rrts_pkg::IDLE_PID;
        live_tasks   = 1;
        cur_slot     = 0;
        pid_next     = rrts_pkg::FIRST_PID;
        idle_slice_m = rrts_pkg::IDLE_SLICE_RST;
        task_slice_m = rrts_pkg::TASK_SLICE_RST;
    endfunction

    function automatic int next_slot(int i);
        return (i + 1 >= live_tasks) ? 0 : i + 1;
    endfunction

    function automatic void round_robin_pick();
        int  from;
        int  pick;
        int  i;
        bit  hit;
        from = cur_slot;
        pick = from;
        hit  = 1'b0;
        i    = next_slot(from);
        while (i != from && !hit) begin
            if (tbl_state[i] == rrts_pkg::TS_READY || tbl_state[i] == rrts_pkg::TS_RUNNING) begin
                pick = i;
                hit  = 1'b1;
            end else begin
                i = next_slot(i);
            end
        end
        if (tbl_state[from] == rrts_pkg::TS_RUNNING)
            tbl_state[from] = rrts_pkg::TS_READY;
        cur_slot = pick;
        tbl_state[pick] = rrts_pkg::TS_RUNNING;
    endfunction

    function automatic t_sched_result schedule_step(logic [1:0] cmd,
                                                    logic [rrts_pkg::PID_W-1:0] pid);
        t_sched_result                r;
        logic [rrts_pkg::SLICE_W-1:0] slice;
        bit                           found;
        r = '0;
        case (cmd)
            rrts_pkg::CMD_TICK: begin
                slice = (cur_slot == 0) ? idle_slice_m : task_slice_m;
                tbl_used[cur_slot]  = tbl_used[cur_slot] + rrts_pkg::SLICE_W'(1);
                tbl_ticks[cur_slot] = tbl_ticks[cur_slot] + rrts_pkg::TICKS_W'(1);
                if (tbl_used[cur_slot] >= slice) begin
                    tbl_used[cur_slot] = '0;
                    round_robin_pick();
                    r.rescheduled = 1'b1;
                end
            end
            rrts_pkg::CMD_YIELD: begin
                round_robin_pick();
                r.rescheduled = 1'b1;
            end
            rrts_pkg::CMD_CREATE: begin
                if (live_tasks >= rrts_pkg::TABLE_DEPTH) begin
                    r.status = rrts_pkg::STAT_FULL;
                end else begin
                    tbl_state[live_tasks] = rrts_pkg::TS_READY;
                    tbl_pid[live_tasks]   = pid_next;
                    tbl_used[live_tasks]  = '0;
                    tbl_ticks[live_tasks] = '0;
                    r.new_pid  = pid_next;
                    pid_next   = pid_next + rrts_pkg::PID_W'(1);
                    live_tasks = live_tasks + 1;
                end
            end
            default: begin
                if (pid == rrts_pkg::IDLE_PID) begin
                    r.status = rrts_pkg::STAT_PROTECTED;
                end else begin
                    r.status = rrts_pkg::STAT_NOT_FOUND;
                    found = 1'b0;
                    for (int i = 0; i < live_tasks; i++) begin
                        if (!found && tbl_pid[i] == pid) begin
                            tbl_state[i] = rrts_pkg::TS_DEAD;
                            r.status = rrts_pkg::STAT_OK;
                            found = 1'b1;
                        end
                    end
                end
            end
        endcase
        r.current_pid = tbl_pid[cur_slot];
        return r;
    endfunction

    task automatic report_mismatch(input string what, input t_sched_result want);
        mismatches++;
        if (mismatches <= 10)
            $display({"mismatch (%s) at %0t: expected st=%0d new=%0d cur=%0d rs=%0d, ",
                      "got st=%0d new=%0d cur=%0d rs=%0d"},
                     what, $realtime, want.status, want.new_pid, want.current_pid,
                     want.rescheduled, o_status, o_new_pid, o_current_pid, o_rescheduled);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1) begin
            if (pending_results.size() == 0) begin
                report_mismatch("no result pending", '0);
            end else begin
                got_want = pending_results.pop_front();
                if (o_status !== got_want.status || o_new_pid !== got_want.new_pid ||
                    o_current_pid !== got_want.current_pid ||
                    o_rescheduled !== got_want.rescheduled)
                    report_mismatch("field", got_want);
            end
        end
    end

    // called at a falling edge; returns at a falling edge with i_start possibly still high
    task automatic send_cmd(input logic [1:0] cmd, input logic [rrts_pkg::PID_W-1:0] pid);
        t_sched_result want;
        i_start      = 1'b1;
        i_cmd        = cmd;
        i_target_pid = pid;
        @(posedge i_clk);
        while (o_busy !== 1'b0) @(posedge i_clk);
        want = schedule_step(cmd, pid);
        pending_results.push_back(want);
        n_cmds++;
        if (want.rescheduled) n_resched++;
        if (cmd == rrts_pkg::CMD_CREATE && want.status == rrts_pkg::STAT_OK) n_created++;
        if (want.status == rrts_pkg::STAT_FULL) n_full++;
        if (cmd == rrts_pkg::CMD_KILL && want.status == rrts_pkg::STAT_OK) n_kill_ok++;
        if (want.status == rrts_pkg::STAT_NOT_FOUND) n_kill_missing++;
        if (want.status == rrts_pkg::STAT_PROTECTED) n_kill_protected++;
        @(negedge i_clk);
        if (gaps_on && $urandom_range(0, 3) == 0) begin
            i_start = 1'b0;
            repeat ($urandom_range(1, 13)) @(negedge i_clk);
        end
    endtask

    // stop commands and wait until every transfer is back and the block is quiet
    task automatic wait_drained();
        int guard;
        i_start = 1'b0;
        guard = 0;
        while (pending_results.size() != 0 && guard < DRAIN_LIMIT) begin
            @(posedge i_clk);
            guard++;
        end
        if (pending_results.size() != 0) begin
            mismatches++;
            $display("%0d results never arrived", pending_results.size());
            pending_results.delete();
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic write_slices(input logic [rrts_pkg::SLICE_W-1:0] idle_s,
                                input logic [rrts_pkg::SLICE_W-1:0] task_s);
        wait_drained();
        i_cfg_valid = 1'b1;
        i_cfg_index = rrts_pkg::CFG_IDLE_SLICE;
        i_cfg_data  = idle_s;
        @(posedge i_clk);
        while (o_cfg_ready !== 1'b1) @(posedge i_clk);
        idle_slice_m = idle_s;
        @(negedge i_clk);
        i_cfg_index = rrts_pkg::CFG_TASK_SLICE;
        i_cfg_data  = task_s;
        @(posedge i_clk);
        while (o_cfg_ready !== 1'b1) @(posedge i_clk);
        task_slice_m = task_s;
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic test_directed_commands();
        send_cmd(rrts_pkg::CMD_TICK, 16'h0000);
        send_cmd(rrts_pkg::CMD_YIELD, 16'hffff);
        send_cmd(rrts_pkg::CMD_KILL, rrts_pkg::IDLE_PID);
        send_cmd(rrts_pkg::CMD_KILL, 16'h0000);
        send_cmd(rrts_pkg::CMD_KILL, 16'hffff);
        send_cmd(rrts_pkg::CMD_CREATE, 16'h5a5a);
        send_cmd(rrts_pkg::CMD_CREATE, 16'h0000);
        send_cmd(rrts_pkg::CMD_YIELD, 16'h0000);
        // kill the running task, it keeps the cpu until the next switch
        send_cmd(rrts_pkg::CMD_KILL, rrts_pkg::FIRST_PID);
        send_cmd(rrts_pkg::CMD_TICK, 16'h0000);
        send_cmd(rrts_pkg::CMD_YIELD, 16'h0000);
        send_cmd(rrts_pkg::CMD_KILL, rrts_pkg::FIRST_PID + rrts_pkg::PID_W'(1));
        send_cmd(rrts_pkg::CMD_YIELD, 16'h0000);
        send_cmd(rrts_pkg::CMD_CREATE, 16'hffff);
    endtask

    task automatic test_slice_expiry();
        write_slices(8'd1, 8'd1);
        repeat (5) send_cmd(rrts_pkg::CMD_TICK, rrts_pkg::PID_W'($urandom_range(0, 16'hffff)));
        send_cmd(rrts_pkg::CMD_YIELD, 16'h0000);
    endtask

    task automatic test_random_schedule(input int count, input int tick_pct,
                                        input logic [rrts_pkg::SLICE_W-1:0] idle_s,
                                        input logic [rrts_pkg::SLICE_W-1:0] task_s);
        int                         r;
        int                         k;
        logic [1:0]                 cmd;
        logic [rrts_pkg::PID_W-1:0] pid;
        write_slices(idle_s, task_s);
        for (int n = 0; n < count; n++) begin
            r   = $urandom_range(0, 99);
            pid = rrts_pkg::PID_W'($urandom_range(0, 16'hffff));
            if (r < tick_pct) begin
                cmd = rrts_pkg::CMD_TICK;
            end else begin
                k = $urandom_range(0, 9);
                if (k < 6) begin
                    cmd = rrts_pkg::CMD_YIELD;
                end else if (k < 8) begin
                    cmd = rrts_pkg::CMD_CREATE;
                end else begin
                    cmd = rrts_pkg::CMD_KILL;
                    k = $urandom_range(0, 19);
                    if (k < 3)
                        pid = rrts_pkg::FIRST_PID +
                              rrts_pkg::PID_W'($urandom_range(0, rrts_pkg::TABLE_DEPTH - 1));
                    else if (k < 7)
                        pid = rrts_pkg::IDLE_PID;
                    else if (k < 8)
                        pid = '0;
                end
            end
            send_cmd(cmd, pid);
        end
    endtask

    task automatic test_back_to_back();
        gaps_on = 1'b0;
        test_random_schedule(400, 60, 8'd2, 8'd7);
    endtask

    initial begin
        i_rst_n      = 1'b0;
        i_start      = 1'b0;
        i_cmd        = rrts_pkg::CMD_TICK;
        i_target_pid = '0;
        i_cfg_valid  = 1'b0;
        i_cfg_index  = rrts_pkg::CFG_IDLE_SLICE;
        i_cfg_data   = '0;
        model_reset();
        repeat (6) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        test_directed_commands();
        test_slice_expiry();
        test_random_schedule(300, 55, 8'd3, 8'd5);
        test_random_schedule(300, 85, 8'd255, 8'd255);
        test_random_schedule(300, 60, 8'd1, 8'd255);
        test_random_schedule(300, 60, 8'd255, 8'd1);
        test_random_schedule(300, 65, rrts_pkg::SLICE_W'($urandom_range(1, 255)),
                             rrts_pkg::SLICE_W'($urandom_range(1, 255)));
        test_back_to_back();
        wait_drained();

        $display("ran %0d commands: %0d reschedules, %0d creates, %0d full-table refusals",
                 n_cmds, n_resched, n_created, n_full);
        $display("kills: %0d done, %0d unknown pid, %0d idle refusals; %0d mismatches",
                 n_kill_ok, n_kill_missing, n_kill_protected, mismatches);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    initial begin
        #10_000_000;
        $display("timeout after %0t", $realtime);
        $display("status: fail");
        $finish;
    end

endmodule
